// ----- rtl/stepper_enable_safety_interlock_assert.svh -----
// ----------------------------------------------------------------------------
// Stepper enable interlock assertion macros
// Concurrent check wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef STEPPER_ENABLE_SAFETY_INTERLOCK_ASSERT_SVH
`define STEPPER_ENABLE_SAFETY_INTERLOCK_ASSERT_SVH

`ifndef ASSERT_OFF

// antecedent holds -> consequent holds in the same cycle
`define SEI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define SEI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SEI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define SEI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/sei_pkg.sv -----
// ----------------------------------------------------------------------------
// Stepper enable interlock package
// Request, mode and register index codes, the clear authorisation code, plus reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sei_pkg;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_CLEAR   = 2'd1,
    REQ_ENABLE  = 2'd2,
    REQ_DISABLE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    MODE_INVALID = 2'd0,
    MODE_MOVE    = 2'd1,
    MODE_STOP    = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CFG_ALWAYS_ENABLED = 2'd0,
    CFG_STOP_DELAY     = 2'd1,
    CFG_STARTUP_DELAY  = 2'd2,
    CFG_ABORT_CONFIRM  = 2'd3
  } cfg_idx_e;

  localparam logic [7:0]  AUTH_OK              = 8'd3;
  localparam logic [15:0] STOP_DELAY_RESET     = 16'd50;
  localparam logic [15:0] STARTUP_DELAY_RESET  = 16'd1000;
  localparam logic [3:0]  ABORT_CONFIRM_RESET  = 4'd3;

endpackage

`default_nettype wire

// ----- rtl/stepper_enable_safety_interlock.sv -----
// ----------------------------------------------------------------------------
// Stepper enable safety interlock
// Driver enable control with abort confirmation, emergency stop delay,
// startup one-shot and invalid-clear lockout.
// ----------------------------------------------------------------------------
// Timing: an accepted input beat is registered in the result register and appears the cycle after it.
// Throughput: one beat per cycle while the result channel is not stalled; the whole pass is one level of compare,
//   decrement and select logic ahead of the state and result registers.
// Reset: asynchronous, active low. Mode is move, driver off, counters zero,
//   startup countdown loaded with 1000, startup one-shot armed, config
//   registers at their defaults. Config port is always ready.
`timescale 1ns / 1ps
`default_nettype none

`include "stepper_enable_safety_interlock_assert.svh"

module stepper_enable_safety_interlock
  import sei_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,

  // request channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic        abort_level_i,
  input  wire logic [7:0]  auth_code_i,

  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             motor_enable_o,
  output logic [1:0]       safety_mode_o,
  output logic             clear_accepted_o
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic        always_en_q;
  logic [15:0] stop_delay_q;
  logic [3:0]  abort_confirm_q;
  logic        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      always_en_q     <= 1'b0;
      stop_delay_q    <= STOP_DELAY_RESET;
      abort_confirm_q <= ABORT_CONFIRM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_ALWAYS_ENABLED: always_en_q     <= cfg_data_i[0];
        CFG_STOP_DELAY:     stop_delay_q    <= cfg_data_i;
        // startup delay only matters as a countdown reload, handled below
        CFG_STARTUP_DELAY:  ;
        CFG_ABORT_CONFIRM:  abort_confirm_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: the result register frees up when it is empty or drained
  // --------------------------------------------------------------------------
  logic out_valid_q;
  logic in_accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Interlock state
  // --------------------------------------------------------------------------
  logic        drive_q,      drive_d;
  mode_e       mode_q,       mode_d;
  logic [3:0]  abort_cnt_q,  abort_cnt_d;
  logic [15:0] stop_cnt_q,   stop_cnt_d;
  logic [15:0] start_cnt_q,  start_cnt_d;
  logic        start_done_q, start_done_d;
  logic        pending_q,    pending_d;

  // per-pass intermediates
  req_e        req;
  mode_e       mode_req;     // mode after the request phase
  logic        accepted;
  logic        oneshot_fire;
  logic        stop_expired; // never held across beats: always consumed in the pass

  assign req = req_e'(req_type_i);

  always_comb begin
    mode_req     = mode_q;
    drive_d      = drive_q;
    accepted     = 1'b0;
    abort_cnt_d  = abort_cnt_q;
    stop_cnt_d   = stop_cnt_q;
    start_cnt_d  = start_cnt_q;
    start_done_d = start_done_q;
    stop_expired = 1'b0;

    // request phase
    unique case (req)
      REQ_CLEAR: begin
        if (auth_code_i == AUTH_OK) begin
          if (!abort_level_i) begin
            mode_req = MODE_MOVE;
            if (always_en_q) drive_d = 1'b1;
            accepted = 1'b1;
          end
        end else begin
          mode_req = MODE_INVALID;
        end
      end
      REQ_ENABLE: begin
        if (mode_q == MODE_MOVE) drive_d = 1'b1;
      end
      REQ_DISABLE: drive_d = 1'b0;
      REQ_TICK: ;
      default: ;
    endcase

    // startup one-shot, first pass after the countdown finished
    oneshot_fire = start_done_q && pending_q;
    pending_d    = pending_q && !oneshot_fire;
    if (oneshot_fire) begin
      if (always_en_q) begin
        if (mode_req == MODE_MOVE) drive_d = 1'b1;
      end else begin
        drive_d = 1'b0;
      end
    end

    mode_d = mode_req;

    // tick work: abort confirmation, stop delay, startup countdown
    if (req == REQ_TICK) begin
      if (abort_level_i) begin
        if (abort_cnt_q < abort_confirm_q) begin
          abort_cnt_d = abort_cnt_q + 4'd1;
        end else if (mode_req != MODE_STOP) begin
          mode_d     = MODE_STOP;
          stop_cnt_d = stop_delay_q;
        end
      end else if (abort_cnt_q != 4'd0) begin
        abort_cnt_d = abort_cnt_q - 4'd1;
      end

      if (mode_d == MODE_STOP) begin
        if (stop_cnt_d != 16'd0) stop_cnt_d = stop_cnt_d - 16'd1;
        else                     stop_expired = 1'b1;
      end

      if (!start_done_q) begin
        if (start_cnt_q != 16'd0) start_cnt_d = start_cnt_q - 16'd1;
        else                      start_done_d = 1'b1;
      end
    end

    // forced disables
    if (mode_d != MODE_STOP && mode_d != MODE_MOVE) drive_d = 1'b0;
    if (stop_expired) drive_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q      <= 1'b0;
      mode_q       <= MODE_MOVE;
      abort_cnt_q  <= 4'd0;
      stop_cnt_q   <= 16'd0;
      start_done_q <= 1'b0;
      pending_q    <= 1'b1;
    end else if (in_accept) begin
      drive_q      <= drive_d;
      mode_q       <= mode_d;
      abort_cnt_q  <= abort_cnt_d;
      stop_cnt_q   <= stop_cnt_d;
      start_done_q <= start_done_d;
      pending_q    <= pending_d;
    end
  end

  // startup countdown also reloads on a delay write while still counting
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_cnt_q <= STARTUP_DELAY_RESET;
    end else begin
      priority if (cfg_we && cfg_idx_e'(cfg_index_i) == CFG_STARTUP_DELAY &&
                   !start_done_q) begin
        start_cnt_q <= cfg_data_i;
      end else if (in_accept) begin
        start_cnt_q <= start_cnt_d;
      end else begin
        start_cnt_q <= start_cnt_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic       motor_enable_q;
  logic [1:0] safety_mode_q;
  logic       clear_accepted_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      motor_enable_q   <= drive_d;
      safety_mode_q    <= mode_d;
      clear_accepted_q <= accepted;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign motor_enable_o   = motor_enable_q;
  assign safety_mode_o    = safety_mode_q;
  assign clear_accepted_o = clear_accepted_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `SEI_ASSERT_SAME(a_invalid_forces_off, clk_i, rst_ni,
    out_valid_q && safety_mode_q == MODE_INVALID, !motor_enable_q,
    "driver enabled in invalid mode")
  `SEI_ASSERT_SAME(a_clear_implies_move, clk_i, rst_ni,
    out_valid_q && clear_accepted_q, safety_mode_q == MODE_MOVE,
    "accepted clear without move mode")
  `SEI_ASSERT_NEXT(a_startup_done_sticky, clk_i, rst_ni,
    start_done_q, start_done_q,
    "startup done flag dropped")
  `SEI_ASSERT_SAME(a_oneshot_after_done, clk_i, rst_ni,
    !pending_q, start_done_q,
    "startup one-shot fired before countdown end")
  `SEI_ASSERT_SAME(a_ready_when_empty, clk_i, rst_ni,
    !out_valid_q, in_ready_o,
    "input stalled with empty result register")

endmodule

`default_nettype wire
